// ----- sv/rrq_pkg.sv -----
// ----------------------------------------------------------------------------
// rrq_pkg: shared types and constants of the round-robin run queue
// Field widths, operation codes and the structs that pass between modules.
// ----------------------------------------------------------------------------
package rrq_pkg;

  // Process ids up to MAX_PROC-1 are served; ids at or above it are rejected.
  localparam int MAX_PROC = 64;

  localparam int PID_W   = 6;
  localparam int DEPTH   = 1 << PID_W;
  localparam int SLICE_W = 8;
  localparam int CNT_W   = 7;

  localparam logic [SLICE_W-1:0] MAX_SLICE_RST = SLICE_W'(5);

  typedef logic [PID_W-1:0]   pid_t;
  typedef logic [SLICE_W-1:0] slice_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    FN_ENQ   = 2'd0,
    FN_DEQ   = 2'd1,
    FN_TICK  = 2'd2,
    FN_QUERY = 2'd3
  } func_t;

  // Per-process entry of the process memory
  typedef struct packed {
    logic   queued;
    slice_t slice;
  } proc_ent_t;

  typedef struct packed {
    func_t func;
    pid_t  pid;
  } op_t;

  typedef struct packed {
    logic en;
    pid_t addr;
    pid_t data;
  } link_wr_t;

  typedef struct packed {
    logic      en;
    pid_t      addr;
    proc_ent_t data;
  } proc_wr_t;

  typedef struct packed {
    logic   resched_req;
    logic   op_error;
    pid_t   head_pid;
    logic   queue_empty;
    cnt_t   queued_count;
    slice_t slice_left;
  } result_t;

endpackage

// ----- sv/rrq_in_if.sv -----
// ----------------------------------------------------------------------------
// rrq_in_if: operation channel of the run queue
// Valid/ready handshake carrying one operation and its process id.
// ----------------------------------------------------------------------------
interface rrq_in_if;
  logic           valid;
  logic           ready;
  rrq_pkg::func_t func;
  rrq_pkg::pid_t  pid;

  modport source (output valid, output func, output pid, input ready);
  modport sink   (input valid, input func, input pid, output ready);
endinterface

// ----- sv/rrq_out_if.sv -----
// ----------------------------------------------------------------------------
// rrq_out_if: result channel of the run queue
// Valid/ready handshake carrying one result per operation.
// ----------------------------------------------------------------------------
interface rrq_out_if;
  logic            valid;
  logic            ready;
  logic            resched_req;
  logic            op_error;
  rrq_pkg::pid_t   head_pid;
  logic            queue_empty;
  rrq_pkg::cnt_t   queued_count;
  rrq_pkg::slice_t slice_left;

  modport source (output valid, output resched_req, output op_error, output head_pid,
                  output queue_empty, output queued_count, output slice_left,
                  input ready);
  modport sink   (input valid, input resched_req, input op_error, input head_pid,
                  input queue_empty, input queued_count, input slice_left,
                  output ready);
endinterface

// ----- sv/rrq_ram.sv -----
// ----------------------------------------------------------------------------
// rrq_ram: generic single-write, single-read synchronous RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/rrq_upd.sv -----
// ----------------------------------------------------------------------------
// rrq_upd: list and slice update of the run queue
// Holds head, tail, count and the process-entry valid bits; turns the read
// data of one operation into memory write-backs and the result.
// ----------------------------------------------------------------------------
module rrq_upd (
  input  logic                clk,
  input  logic                rst_n,
  input  rrq_pkg::op_t        op,
  input  logic                commit,
  input  rrq_pkg::slice_t     max_slice,
  input  rrq_pkg::proc_ent_t  proc_rd,
  input  rrq_pkg::pid_t       next_rd,
  input  rrq_pkg::pid_t       prev_rd,
  output rrq_pkg::proc_wr_t   proc_wr,
  output rrq_pkg::link_wr_t   next_wr,
  output rrq_pkg::link_wr_t   prev_wr,
  output rrq_pkg::result_t    res
);

  rrq_pkg::pid_t             head_r, head_nxt;
  rrq_pkg::pid_t             tail_r, tail_nxt;
  rrq_pkg::cnt_t             count_r, count_nxt;
  logic [rrq_pkg::DEPTH-1:0] valid_r;

  rrq_pkg::proc_ent_t cur;
  rrq_pkg::proc_ent_t ent_new;
  logic               pid_ok;
  logic               proc_we, next_we, prev_we;
  logic               err, resched;

  always_comb begin
    // an entry never written reads as not queued with zero slice
    cur      = valid_r[op.pid] ? proc_rd : '0;
    pid_ok   = (32'(op.pid) < rrq_pkg::MAX_PROC);
    ent_new  = cur;
    head_nxt = head_r;
    tail_nxt = tail_r;
    count_nxt = count_r;
    proc_we  = 1'b0;
    next_we  = 1'b0;
    prev_we  = 1'b0;
    next_wr.addr = tail_r;
    next_wr.data = op.pid;
    prev_wr.addr = op.pid;
    prev_wr.data = tail_r;
    err      = 1'b0;
    resched  = 1'b0;

    if (!pid_ok) begin
      err = (op.func == rrq_pkg::FN_ENQ) || (op.func == rrq_pkg::FN_DEQ);
    end else begin
      unique case (op.func)
        rrq_pkg::FN_ENQ: begin
          if (cur.queued) begin
            err = 1'b1;
          end else begin
            if (count_r == '0) begin
              head_nxt = op.pid;
            end else begin
              // link behind the current tail
              next_we = 1'b1;
              prev_we = 1'b1;
            end
            tail_nxt       = op.pid;
            count_nxt      = count_r + rrq_pkg::CNT_W'(1);
            ent_new.queued = 1'b1;
            if ((cur.slice == '0) || (cur.slice > max_slice)) begin
              ent_new.slice = max_slice;
            end
            proc_we = 1'b1;
          end
        end
        rrq_pkg::FN_DEQ: begin
          if (!cur.queued) begin
            err = 1'b1;
          end else begin
            priority if (count_r <= rrq_pkg::CNT_W'(1)) begin
              head_nxt = '0;
              tail_nxt = '0;
            end else if (op.pid == head_r) begin
              head_nxt = next_rd;
            end else if (op.pid == tail_r) begin
              tail_nxt = prev_rd;
            end else begin
              // splice neighbors around the removed entry
              next_we      = 1'b1;
              next_wr.addr = prev_rd;
              next_wr.data = next_rd;
              prev_we      = 1'b1;
              prev_wr.addr = next_rd;
              prev_wr.data = prev_rd;
            end
            count_nxt      = count_r - rrq_pkg::CNT_W'(1);
            ent_new.queued = 1'b0;
            proc_we        = 1'b1;
          end
        end
        rrq_pkg::FN_TICK: begin
          if (cur.slice != '0) begin
            ent_new.slice = cur.slice - rrq_pkg::SLICE_W'(1);
          end
          resched = (ent_new.slice == '0);
          proc_we = 1'b1;
        end
        rrq_pkg::FN_QUERY: begin
        end
      endcase
    end

    proc_wr.en   = proc_we & commit;
    proc_wr.addr = op.pid;
    proc_wr.data = ent_new;
    next_wr.en   = next_we & commit;
    prev_wr.en   = prev_we & commit;

    res.resched_req  = resched;
    res.op_error     = err;
    res.head_pid     = (count_nxt == '0) ? '0 : head_nxt;
    res.queue_empty  = (count_nxt == '0);
    res.queued_count = count_nxt;
    res.slice_left   = pid_ok ? ent_new.slice : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      valid_r <= '0;
    end else if (commit) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      if (proc_we) begin
        valid_r[op.pid] <= 1'b1;
      end
    end
  end

endmodule

// ----- sv/round_robin_run_queue_unit.sv -----
// ----------------------------------------------------------------------------
// round_robin_run_queue_unit: round-robin run queue of process ids
// Operations arrive on in_ch (func, pid): enqueue at tail, dequeue from any
// position, tick the time slice, or query. Each operation returns exactly one
// result on out_ch with the pick-next head, empty flag, count, the slice of
// pid and the resched/error flags. cfg_we/cfg_wdata write max_slice (reset 5).
// An accepted operation reads the link and process memories at its pid on
// the accepting edge; the update stage then writes back and loads the result
// once the output register is free. No new operation is taken while one
// still sits in the update stage.
// Reset (synchronous, rst_n low) empties the queue and clears the per-process
// valid bits at once; there is no clearing pass over the memories.
// When out_ch stalls, the result holds in the output register and one more
// operation is accepted; it waits in the update stage until the output frees.
// ----------------------------------------------------------------------------
module round_robin_run_queue_unit (
  input  logic              clk,
  input  logic              rst_n,
  rrq_in_if.sink            in_ch,
  rrq_out_if.source         out_ch,
  input  logic              cfg_we,
  input  rrq_pkg::slice_t   cfg_wdata
);

  // Handshake and operation registers
  logic               busy_r;        // an operation sits in the update stage
  rrq_pkg::op_t       op_r;
  logic               out_valid_r;
  rrq_pkg::result_t   out_r;
  rrq_pkg::slice_t    max_slice_r;

  logic               accept;
  logic               commit;

  // Memory traffic
  rrq_pkg::proc_ent_t proc_rd;
  rrq_pkg::pid_t      next_rd;
  rrq_pkg::pid_t      prev_rd;
  rrq_pkg::proc_wr_t  proc_wr;
  rrq_pkg::link_wr_t  next_wr;
  rrq_pkg::link_wr_t  prev_wr;
  rrq_pkg::result_t   res;

  // Take a new operation whenever the update stage is free; memory reads
  // launch on the same edge at the incoming pid.
  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid & in_ch.ready;

  // Write back and load the result once the output register can take it.
  assign commit = busy_r & (!out_valid_r | out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      max_slice_r <= rrq_pkg::MAX_SLICE_RST;
    end else begin
      if (cfg_we) begin
        max_slice_r <= cfg_wdata;
      end
      if (accept) begin
        busy_r <= 1'b1;
      end else if (commit) begin
        busy_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r.func <= in_ch.func;
      op_r.pid  <= in_ch.pid;
    end
    if (commit) begin
      out_r <= res;
    end
  end

  // Per-process queued flag and slice
  rrq_ram #(
    .WIDTH ($bits(rrq_pkg::proc_ent_t)),
    .DEPTH (rrq_pkg::DEPTH)
  ) u_proc_ram (
    .clk   (clk),
    .we    (proc_wr.en),
    .waddr (proc_wr.addr),
    .wdata (proc_wr.data),
    .re    (accept),
    .raddr (in_ch.pid),
    .rdata (proc_rd)
  );

  // Forward links of the list
  rrq_ram #(
    .WIDTH (rrq_pkg::PID_W),
    .DEPTH (rrq_pkg::DEPTH)
  ) u_next_ram (
    .clk   (clk),
    .we    (next_wr.en),
    .waddr (next_wr.addr),
    .wdata (next_wr.data),
    .re    (accept),
    .raddr (in_ch.pid),
    .rdata (next_rd)
  );

  // Backward links of the list
  rrq_ram #(
    .WIDTH (rrq_pkg::PID_W),
    .DEPTH (rrq_pkg::DEPTH)
  ) u_prev_ram (
    .clk   (clk),
    .we    (prev_wr.en),
    .waddr (prev_wr.addr),
    .wdata (prev_wr.data),
    .re    (accept),
    .raddr (in_ch.pid),
    .rdata (prev_rd)
  );

  rrq_upd u_upd (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op_r),
    .commit    (commit),
    .max_slice (max_slice_r),
    .proc_rd   (proc_rd),
    .next_rd   (next_rd),
    .prev_rd   (prev_rd),
    .proc_wr   (proc_wr),
    .next_wr   (next_wr),
    .prev_wr   (prev_wr),
    .res       (res)
  );

  // Drive the result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.resched_req  = out_r.resched_req;
  assign out_ch.op_error     = out_r.op_error;
  assign out_ch.head_pid     = out_r.head_pid;
  assign out_ch.queue_empty  = out_r.queue_empty;
  assign out_ch.queued_count = out_r.queued_count;
  assign out_ch.slice_left   = out_r.slice_left;

`ifndef ASSERT_OFF
  // A rejected operation must leave the lists untouched.
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && res.op_error) |-> (!next_wr.en && !prev_wr.en && !proc_wr.en))
    else $error("rejected transaction wrote queue state");

  // Empty flag and count of a delivered result agree, and the count is bounded.
  a_count_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_r.queue_empty == (out_r.queued_count == '0)) &&
                     (32'(out_r.queued_count) <= rrq_pkg::DEPTH)))
    else $error("queue count and empty flag disagree");

  // A committed operation frees the update stage on the next cycle.
  a_commit_frees: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> in_ch.ready)
    else $error("update stage still busy after commit");
`endif

endmodule

// ----- sim/tb_round_robin_run_queue_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_round_robin_run_queue_unit: self-checking bench for the run queue
// Operations stream in on in_ch from a queue of pending transactions. A
// behavioral copy of the run queue predicts every result, and each result on
// out_ch is checked field by field against the oldest prediction. Both
// channels idle at random. max_slice changes between phases while the block
// is idle.
// ----------------------------------------------------------------------------
module tb_round_robin_run_queue_unit;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  rrq_pkg::slice_t cfg_wdata;

  rrq_in_if  in_ch ();
  rrq_out_if out_ch ();

  round_robin_run_queue_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Behavioral run queue: doubly linked list over process ids plus slices
  // --------------------------------------------------------------------------
  rrq_pkg::pid_t   nxt_pid [rrq_pkg::DEPTH];
  rrq_pkg::pid_t   prv_pid [rrq_pkg::DEPTH];
  logic            in_queue [rrq_pkg::DEPTH];
  rrq_pkg::slice_t slice_of [rrq_pkg::DEPTH];
  rrq_pkg::pid_t   first_pid;
  rrq_pkg::pid_t   last_pid;
  rrq_pkg::cnt_t   n_queued;
  rrq_pkg::slice_t slice_max;

  rrq_pkg::op_t     ops_to_issue [$];
  rrq_pkg::result_t predicted_results [$];

  int issued_n;
  int accepted_n;
  int got_n;
  int mismatches;

  // Link a process in at the tail
  function automatic void link_tail(rrq_pkg::pid_t p);
    if (n_queued == 0) begin
      first_pid = p;
    end else begin
      nxt_pid[last_pid] = p;
      prv_pid[p] = last_pid;
    end
    last_pid = p;
    in_queue[p] = 1'b1;
    n_queued++;
  endfunction

  // Unlink a queued process from any position
  function automatic void unlink(rrq_pkg::pid_t p);
    if (n_queued <= 1) begin
      first_pid = '0;
      last_pid = '0;
    end else if (p == first_pid) begin
      first_pid = nxt_pid[p];
    end else if (p == last_pid) begin
      last_pid = prv_pid[p];
    end else begin
      nxt_pid[prv_pid[p]] = nxt_pid[p];
      prv_pid[nxt_pid[p]] = prv_pid[p];
    end
    in_queue[p] = 1'b0;
    if (n_queued > 0) n_queued--;
  endfunction

  // Apply one operation to the run queue and return the result it yields
  function automatic rrq_pkg::result_t run_queue_apply(rrq_pkg::func_t f,
                                                       rrq_pkg::pid_t p);
    rrq_pkg::result_t r;
    r = '0;
    if (int'(p) >= rrq_pkg::MAX_PROC) begin
      // ids beyond the table change nothing
      r.op_error = (f == rrq_pkg::FN_ENQ) || (f == rrq_pkg::FN_DEQ);
    end else begin
      case (f)
        rrq_pkg::FN_ENQ: begin
          if (in_queue[p]) begin
            r.op_error = 1'b1;
          end else begin
            link_tail(p);
            if (slice_of[p] == 0 || slice_of[p] > slice_max) slice_of[p] = slice_max;
          end
        end
        rrq_pkg::FN_DEQ: begin
          if (!in_queue[p]) r.op_error = 1'b1;
          else unlink(p);
        end
        rrq_pkg::FN_TICK: begin
          // count down even when the process is not queued
          if (slice_of[p] > 0) slice_of[p]--;
          if (slice_of[p] == 0) r.resched_req = 1'b1;
        end
        default: begin
        end
      endcase
      r.slice_left = slice_of[p];
    end
    r.head_pid     = (n_queued == 0) ? rrq_pkg::pid_t'(0) : first_pid;
    r.queue_empty  = (n_queued == 0);
    r.queued_count = n_queued;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Idle draws: a random wait per transaction, with runs of back-to-back traffic
  // --------------------------------------------------------------------------
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present pending operations on in_ch at the falling edge
  // --------------------------------------------------------------------------
  int           in_gap;
  int           in_calm;
  rrq_pkg::op_t next_op;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_ch.valid || accepted_n == issued_n) begin
      // the channel is free: the last transaction went through or none is up
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (ops_to_issue.size() > 0) begin
        next_op = ops_to_issue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func  <= next_op.func;
        in_ch.pid   <= next_op.pid;
        issued_n++;
        in_gap = draw_wait(in_calm);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result-side back-pressure: stall a fresh number of cycles per result
  int out_wait;
  int out_calm;
  int got_seen;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (got_n != got_seen) begin
        got_seen = got_n;
        out_wait = draw_wait(out_calm);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each accepted operation, check each accepted result
  // --------------------------------------------------------------------------
  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  rrq_pkg::result_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(run_queue_apply(in_ch.func, in_ch.pid));
        accepted_n++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got_n++;
        if (predicted_results.size() == 0) begin
          $display("%0t: result expected none, actual head %0d count %0d slice %0d",
                   $time, out_ch.head_pid, out_ch.queued_count, out_ch.slice_left);
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("resched_req", int'(want.resched_req), int'(out_ch.resched_req));
          check_field("op_error", int'(want.op_error), int'(out_ch.op_error));
          check_field("head_pid", int'(want.head_pid), int'(out_ch.head_pid));
          check_field("queue_empty", int'(want.queue_empty), int'(out_ch.queue_empty));
          check_field("queued_count", int'(want.queued_count),
                      int'(out_ch.queued_count));
          check_field("slice_left", int'(want.slice_left), int'(out_ch.slice_left));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_op(rrq_pkg::func_t f, rrq_pkg::pid_t p);
    rrq_pkg::op_t o;
    o.func = f;
    o.pid  = p;
    ops_to_issue.push_back(o);
  endtask

  // Random operations over a window of ids; a narrow window keeps enqueue
  // and dequeue hitting each other, a tenth of the ids come from anywhere.
  task automatic add_random_ops(int n, int window, int enq_pct, int deq_pct, int tick_pct);
    int             base;
    int             r;
    rrq_pkg::func_t f;
    rrq_pkg::pid_t  p;
    base = $urandom_range(0, rrq_pkg::DEPTH - 1);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct) f = rrq_pkg::FN_ENQ;
      else if (r < enq_pct + deq_pct) f = rrq_pkg::FN_DEQ;
      else if (r < enq_pct + deq_pct + tick_pct) f = rrq_pkg::FN_TICK;
      else f = rrq_pkg::FN_QUERY;
      if ($urandom_range(0, 9) == 0) begin
        p = rrq_pkg::pid_t'($urandom_range(0, rrq_pkg::DEPTH - 1));
      end else begin
        p = rrq_pkg::pid_t'((base + $urandom_range(0, window - 1)) % rrq_pkg::DEPTH);
      end
      add_op(f, p);
    end
  endtask

  // Hold until every queued transaction went in and every result came out
  task automatic wait_idle();
    while (ops_to_issue.size() != 0 || accepted_n != issued_n ||
           predicted_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write max_slice while idle and track it in the predictor
  task automatic set_max_slice(rrq_pkg::slice_t v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    slice_max = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rrq_pkg::pid_t order [rrq_pkg::DEPTH];
    rrq_pkg::pid_t t;
    int            j;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = rrq_pkg::FN_QUERY;
    in_ch.pid    = '0;
    out_ch.ready = 1'b0;

    for (int i = 0; i < rrq_pkg::DEPTH; i++) begin
      nxt_pid[i]  = '0;
      prv_pid[i]  = '0;
      in_queue[i] = 1'b0;
      slice_of[i] = '0;
    end
    first_pid = '0;
    last_pid  = '0;
    n_queued  = '0;
    slice_max = rrq_pkg::MAX_SLICE_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty queue, error cases, tick of an unqueued id, removal
    // from head, middle and tail, slice kept on re-enqueue (reset max_slice)
    add_op(rrq_pkg::FN_QUERY, 6'd0);
    add_op(rrq_pkg::FN_DEQ,   6'd0);
    add_op(rrq_pkg::FN_TICK,  6'd63);
    add_op(rrq_pkg::FN_TICK,  6'd63);
    add_op(rrq_pkg::FN_ENQ,   6'd0);
    add_op(rrq_pkg::FN_ENQ,   6'd63);
    add_op(rrq_pkg::FN_ENQ,   6'd21);
    add_op(rrq_pkg::FN_ENQ,   6'd42);
    add_op(rrq_pkg::FN_ENQ,   6'd63);
    add_op(rrq_pkg::FN_TICK,  6'd63);
    add_op(rrq_pkg::FN_TICK,  6'd63);
    add_op(rrq_pkg::FN_DEQ,   6'd21);
    add_op(rrq_pkg::FN_DEQ,   6'd0);
    add_op(rrq_pkg::FN_DEQ,   6'd42);
    add_op(rrq_pkg::FN_QUERY, 6'd63);
    add_op(rrq_pkg::FN_DEQ,   6'd63);
    add_op(rrq_pkg::FN_DEQ,   6'd63);
    add_op(rrq_pkg::FN_ENQ,   6'd63);
    add_op(rrq_pkg::FN_TICK,  6'd63);
    add_op(rrq_pkg::FN_TICK,  6'd63);
    add_op(rrq_pkg::FN_TICK,  6'd63);
    add_op(rrq_pkg::FN_TICK,  6'd63);
    add_op(rrq_pkg::FN_QUERY, 6'd0);
    wait_idle();

    // Smallest nonzero slice: ticks drain fast, dense enqueue/dequeue traffic
    set_max_slice(8'd1);
    add_random_ops(100, 8, 40, 30, 20);
    wait_idle();

    // Largest slice: fill the queue completely, then drain it at random
    set_max_slice(8'd255);
    for (int i = 0; i < rrq_pkg::DEPTH; i++) order[i] = rrq_pkg::pid_t'(i);
    for (int i = rrq_pkg::DEPTH - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (int i = 0; i < rrq_pkg::DEPTH; i++) add_op(rrq_pkg::FN_ENQ, order[i]);
    add_random_ops(50, rrq_pkg::DEPTH, 10, 60, 20);
    wait_idle();

    // Zero slice: enqueue leaves the slice at zero
    set_max_slice(8'd0);
    add_random_ops(60, 16, 40, 25, 25);
    wait_idle();

    // Random mid-range slice
    set_max_slice(rrq_pkg::slice_t'($urandom_range(2, 254)));
    add_random_ops(120, 12, 35, 30, 25);
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rrq_pkg.sv
sv/rrq_in_if.sv
sv/rrq_out_if.sv
sv/rrq_ram.sv
sv/rrq_upd.sv
sv/round_robin_run_queue_unit.sv
sim/tb_round_robin_run_queue_unit.sv
